@@ rtl/core/fxmd_pkg.sv @@
// Shared types and constants for the Q16.16 multiply/divide pipeline.
// No dependencies; every module of the block imports this package.
`default_nettype none

package fxmd_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_SHIFT = 14;
  localparam int QUO_BITS    = GUARD_SHIFT + FRAC_BITS;

  typedef enum logic {
    KIND_MUL = 1'b0,
    KIND_DIV = 1'b1
  } kind_t;

  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                sat;
    logic                neg;
    logic [DATA_W-1:0]   rem;
    logic [QUO_BITS-1:0] dvd;
    logic [DATA_W-1:0]   bb;
    logic [DATA_W-1:0]   res;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/fxmd_prep.sv @@
// Entry stage: operand magnitudes, divide guard and multiply partial products.
// Depends on fxmd_pkg.
`default_nettype none

module fxmd_prep
  import fxmd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire logic                     req_valid,
  input  wire logic                     kind,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output      stage_t                   q
);

  logic [DATA_W-1:0]        aa;
  logic [DATA_W-1:0]        bb;
  logic [DATA_W-1:0]        sh;
  logic                     guard;
  logic signed [2*DATA_W-FRAC_BITS:0]   p_lo;
  logic signed [2*DATA_W-FRAC_BITS-1:0] p_hi;
  kind_t                    k;

  always_comb begin
    k     = kind_t'(kind);
    aa    = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    bb    = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
    sh    = DATA_W'($signed(aa) >>> GUARD_SHIFT);
    guard = sh >= bb;
    p_lo  = $signed(a) * $signed({1'b0, b[FRAC_BITS-1:0]});
    p_hi  = $signed(a) * $signed(b[DATA_W-1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (advance) begin
      q.valid <= req_valid;
    end
    if (advance) begin
      q.kind <= k;
      q.sat  <= (k == KIND_DIV) && guard;
      q.neg  <= a[DATA_W-1] ^ b[DATA_W-1];
      q.bb   <= bb;
      q.dvd  <= {aa[GUARD_SHIFT-1:0], FRAC_BITS'(0)};
      if (k == KIND_MUL) begin
        q.res <= p_hi[DATA_W-1:0];
        q.rem <= p_lo[DATA_W+FRAC_BITS-1:FRAC_BITS];
      end else begin
        q.res <= '0;
        q.rem <= sh;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fxmd_div_step.sv @@
// One restoring-division stage: one quotient bit per stage.
// Multiply beats fold their partial products here and then pass unchanged.
// Depends on fxmd_pkg.
`default_nettype none

module fxmd_div_step
  import fxmd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  wire stage_t d,
  output      stage_t q
);

  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            ge;

  always_comb begin
    trial = {d.rem, d.dvd[QUO_BITS-1]};
    diff  = trial - {1'b0, d.bb};
    ge    = ~diff[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (advance) begin
      q.valid <= d.valid;
    end
    if (advance) begin
      q.kind <= d.kind;
      q.sat  <= d.sat;
      q.neg  <= d.neg;
      q.bb   <= d.bb;
      q.dvd  <= {d.dvd[QUO_BITS-2:0], 1'b0};
      if (d.kind == KIND_MUL) begin
        q.res <= d.res + d.rem;
        q.rem <= '0;
      end else begin
        q.res <= {d.res[DATA_W-2:0], ge};
        q.rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fxmd_out.sv @@
// Output register: quotient sign, saturation select and response handshake.
// Depends on fxmd_pkg.
`default_nettype none

module fxmd_out
  import fxmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire stage_t            d,
  input  wire logic              rsp_ready,
  output      logic              advance,
  output      logic              rsp_valid,
  output      logic [DATA_W-1:0] result,
  output      logic              saturated
);

  logic [DATA_W-1:0] res_next;

  assign advance = ~rsp_valid | rsp_ready;

  always_comb begin
    if (d.kind == KIND_MUL) begin
      res_next = d.res;
    end else if (d.sat) begin
      res_next = d.neg ? SAT_MIN : SAT_MAX;
    end else begin
      res_next = d.neg ? DATA_W'(-d.res) : d.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= d.valid;
    end
    if (advance) begin
      result    <= res_next;
      saturated <= d.sat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fixed_16_16_mul_div.sv @@
// Top level of the Q16.16 multiply/divide unit: entry stage, division stages, output.
// Depends on fxmd_pkg, fxmd_prep, fxmd_div_step and fxmd_out.
//
//   channel | signals                         | beat
//   req     | req_valid req_ready kind a b    | one operation
//   rsp     | rsp_valid rsp_ready result sat. | one result per operation
//
// One beat enters per cycle unless a result waits on rsp_ready; each result is
// presented after its request is accepted and passes the entry stage, 30 division
// stages and the output register.
// Reset clears every stage valid bit; payload registers are not reset.
// While a result waits on rsp_ready the whole pipeline holds; empty output
// register or a taken result lets every stage advance together.
`default_nettype none

module fixed_16_16_mul_div
  import fxmd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output      logic                     req_ready,
  input  wire logic                     kind,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output      logic                     rsp_valid,
  input  wire logic                     rsp_ready,
  output      logic signed [DATA_W-1:0] result,
  output      logic                     saturated
);

  logic              advance;
  logic [DATA_W-1:0] res_bits;
  stage_t            pipe [0:QUO_BITS];

  assign req_ready = advance;
  assign result    = $signed(res_bits);

  fxmd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .req_valid (req_valid),
    .kind      (kind),
    .a         (a),
    .b         (b),
    .q         (pipe[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    fxmd_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .d       (pipe[i]),
      .q       (pipe[i+1])
    );
  end

  fxmd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .d         (pipe[QUO_BITS]),
    .rsp_ready (rsp_ready),
    .advance   (advance),
    .rsp_valid (rsp_valid),
    .result    (res_bits),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

@@ rtl/core/fxmd_checker.sv @@
// Port-level checks for the Q16.16 multiply/divide unit, bound to the top level.
// Depends on fxmd_pkg and fixed_16_16_mul_div.
`default_nettype none

module fxmd_checker
  import fxmd_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire logic signed [DATA_W-1:0] result,
  input wire logic                     saturated
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) && $stable(saturated))
    else $error("held response beat changed");

  a_ready_follows_rsp: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("request ready does not track output slot");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && saturated |-> result == $signed(SAT_MIN) || result == $signed(SAT_MAX))
    else $error("saturated beat carries a non-limit value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind fixed_16_16_mul_div fxmd_checker u_fxmd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .result    (result),
  .saturated (saturated)
);

`default_nettype wire

@@ verif/tb_fixed_16_16_mul_div.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Q16.16 multiply/divide unit fixed_16_16_mul_div.
// Depends on fxmd_pkg and the block's RTL. Directed corners and random operations are
// sent over the valid/ready channels and each result is checked against an in-bench model.
module tb_fixed_16_16_mul_div;
  import fxmd_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              sat;
  } q16_out_t;

  logic                     clk;
  logic                     rst;
  logic                     req_valid;
  logic                     req_ready;
  logic                     kind;
  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W-1:0] b;
  logic                     rsp_valid;
  logic                     rsp_ready;
  logic signed [DATA_W-1:0] result;
  logic                     saturated;

  q16_out_t q16_due[$];
  int       fails = 0;
  int       quiet_cycles = 0;
  bit       src_idle = 1'b0;
  bit       sink_idle = 1'b0;

  fixed_16_16_mul_div dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .a         (a),
    .b         (b),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .result    (result),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic q16_out_t q16_compute(kind_t k, logic signed [DATA_W-1:0] x,
                                           logic signed [DATA_W-1:0] y);
    logic signed [63:0] wx;
    logic signed [63:0] wy;
    logic signed [63:0] wide;
    logic [DATA_W-1:0]  mx;
    logic [DATA_W-1:0]  my;
    logic [DATA_W-1:0]  guard;
    q16_out_t           r;
    wx = x;
    wy = y;
    r.sat = 1'b0;
    if (k == KIND_MUL) begin
      wide = wx * wy;
      r.result = wide[DATA_W+FRAC_BITS-1:FRAC_BITS];
    end else begin
      mx = x[DATA_W-1] ? (~x + 1'b1) : x;
      my = y[DATA_W-1] ? (~y + 1'b1) : y;
      guard = $signed(mx) >>> GUARD_SHIFT;
      if (guard >= my) begin
        r.sat = 1'b1;
        r.result = (x[DATA_W-1] ^ y[DATA_W-1]) ? SAT_MIN : SAT_MAX;
      end else begin
        wide = (wx <<< FRAC_BITS) / wy;
        r.result = wide[DATA_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_fx();
    logic [DATA_W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0, 1: ;
      2: v = {{12{v[19]}}, v[19:0]};
      3: begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = 32'd1;
          2: v = '1;
          3: v = SAT_MIN;
          4: v = SAT_MAX;
          5: v = 32'h0001_0000;
          6: v = 32'hFFFF_0000;
          default: v = 32'h0000_8000;
        endcase
      end
      4: begin
        v = 32'd1 << $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      default: begin
        v = v >> $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  // Hold the beat until it is taken; optionally drop valid for a burst first.
  task automatic send_op(input kind_t k, input logic [DATA_W-1:0] x,
                         input logic [DATA_W-1:0] y);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    a         <= x;
    b         <= y;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic test_mul_corners();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_op(KIND_MUL, 32'h0, 32'h0);
    send_op(KIND_MUL, SAT_MAX, SAT_MAX);
    send_op(KIND_MUL, SAT_MIN, SAT_MIN);
    send_op(KIND_MUL, SAT_MIN, SAT_MAX);
    send_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_MUL, 32'h0001_0000, 32'h0001_0000);
    send_op(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send_op(KIND_MUL, 32'hFFFE_8000, 32'h0001_8000);
  endtask

  task automatic test_div_corners();
    send_op(KIND_DIV, 32'h0001_0000, 32'h0);
    send_op(KIND_DIV, 32'hFFFF_0000, 32'h0);
    send_op(KIND_DIV, 32'h0, 32'h0);
    send_op(KIND_DIV, SAT_MIN, 32'h0000_0001);
    send_op(KIND_DIV, SAT_MIN, SAT_MIN);
    send_op(KIND_DIV, SAT_MAX, 32'hFFFF_FFFF);
    send_op(KIND_DIV, 32'h0004_0000, 32'd16);
    send_op(KIND_DIV, 32'h0004_0000, 32'd17);
    send_op(KIND_DIV, 32'hFFFC_0000, 32'd16);
    send_op(KIND_DIV, 32'hFFFC_0000, 32'hFFFF_FFEF);
    send_op(KIND_DIV, 32'hFFFF_FFFF, 32'd3);
    send_op(KIND_DIV, 32'h0000_0001, 32'hFFFF_FFFD);
    send_op(KIND_DIV, 32'h0000_0001, SAT_MIN);
    send_op(KIND_DIV, SAT_MAX, SAT_MIN);
    send_op(KIND_DIV, 32'h7FFF_0000, 32'h7FFF_0000);
  endtask

  task automatic send_random_op();
    kind_t             k;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] m;
    k = kind_t'($urandom_range(0, 1));
    x = rand_fx();
    y = rand_fx();
    // Land the divisor near the saturation guard.
    if (k == KIND_DIV && $urandom_range(0, 3) == 0) begin
      m = (x[DATA_W-1] ? (~x + 1'b1) : x) >> GUARD_SHIFT;
      m = m + $urandom_range(0, 2) - 1;
      y = $urandom_range(0, 1) ? (~m + 1'b1) : m;
    end
    send_op(k, x, y);
  endtask

  task automatic test_random_mixed(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: begin src_idle = 1'b1; sink_idle = 1'b1; end
          1: begin src_idle = 1'b1; sink_idle = 1'b0; end
          2: begin src_idle = 1'b0; sink_idle = 1'b1; end
          default: begin src_idle = 1'b0; sink_idle = 1'b0; end
        endcase
      end
      send_random_op();
    end
  endtask

  task automatic test_drain_pause();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    for (int i = 0; i < 20; i++) send_random_op();
    req_valid <= 1'b0;
    while (q16_due.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_random_op();
  endtask

  task automatic test_streaming(input int n);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    for (int i = 0; i < n; i++) send_random_op();
  endtask

  initial begin
    rsp_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_idle && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check
    q16_out_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (rsp_valid && rsp_ready) begin
        quiet_cycles = 0;
        if (q16_due.size() == 0) begin
          $error("result beat with no operation outstanding: result=%h", result);
          fails++;
        end else begin
          want = q16_due.pop_front();
          if (result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, result);
            fails++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, saturated);
            fails++;
          end
        end
      end
      if (req_valid && req_ready) begin
        quiet_cycles = 0;
        q16_due.push_back(q16_compute(kind_t'(kind), a, b));
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    kind      <= KIND_MUL;
    a         <= '0;
    b         <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_mul_corners();
    test_div_corners();
    test_random_mixed(540);
    test_drain_pause();
    test_streaming(260);
    req_valid <= 1'b0;
    while (q16_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fxmd_pkg.sv
rtl/core/fxmd_prep.sv
rtl/core/fxmd_div_step.sv
rtl/core/fxmd_out.sv
rtl/core/fixed_16_16_mul_div.sv
rtl/core/fxmd_checker.sv
verif/tb_fixed_16_16_mul_div.sv
